/* rtl/modbus_rtu_master_frame_engine_top_defines.svh */
// Assertion macros shared by the frame engine checker.
`ifndef MODBUS_RTU_MASTER_FRAME_ENGINE_TOP_DEFINES_SVH
`define MODBUS_RTU_MASTER_FRAME_ENGINE_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define MBM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define MBM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/mbm_pkg.sv */
package mbm_pkg;

  // input item codes
  localparam logic [1:0] REQ_READ  = 2'd0;
  localparam logic [1:0] REQ_WRITE = 2'd1;
  localparam logic [1:0] REQ_BYTE  = 2'd2;
  localparam logic [1:0] REQ_TICK  = 2'd3;

  // result kinds
  localparam logic [1:0] KIND_TX     = 2'd0;
  localparam logic [1:0] KIND_WORD   = 2'd1;
  localparam logic [1:0] KIND_STATUS = 2'd2;

  // status codes
  localparam logic [2:0] STAT_OK      = 3'd0;
  localparam logic [2:0] STAT_TIMEOUT = 3'd1;
  localparam logic [2:0] STAT_CRC     = 3'd2;
  localparam logic [2:0] STAT_EXC     = 3'd3;
  localparam logic [2:0] STAT_FRAME   = 3'd4;

  localparam logic [7:0]  FUNC_READ     = 8'h03;
  localparam logic [7:0]  FUNC_WRITE    = 8'h06;
  localparam logic [7:0]  EXC_MASK      = 8'h80;
  localparam logic [15:0] CRC_INIT      = 16'hFFFF;
  localparam logic [15:0] CRC_POLY      = 16'hA001;
  localparam logic [15:0] TIMEOUT_RST   = 16'd1000;
  localparam logic [7:0]  EXC_LEN       = 8'd5;
  localparam logic [7:0]  READ_HDR_LEN  = 8'd5;
  localparam logic [7:0]  WRITE_LEN     = 8'd8;
  localparam logic [7:0]  FUNC_IDX      = 8'd1;
  localparam logic [7:0]  DATA_IDX      = 8'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_TX,
    ST_WORDS
  } ctl_state_e;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_READ,
    PH_WRITE
  } phase_e;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [7:0]  slave_addr;
    logic [15:0] reg_addr;
    logic [15:0] count_or_value;
    logic [7:0]  rx_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  tx_byte;
    logic [15:0] reg_word;
    logic [2:0]  status;
    logic        last;
  } out_item_t;

  // one transmit beat offered by the frame emitter
  typedef struct packed {
    logic       valid;
    logic [7:0] data;
    logic       last;
  } tx_beat_t;

  // CRC-16, reflected, one byte
  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

  function automatic out_item_t mk_status(input logic [2:0] st);
    out_item_t o;
    o.kind     = KIND_STATUS;
    o.tx_byte  = 8'h00;
    o.reg_word = 16'h0000;
    o.status   = st;
    o.last     = 1'b1;
    return o;
  endfunction

endpackage

/* rtl/mbm_ram.sv */
module mbm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/mbm_frame_tx.sv */
module mbm_frame_tx (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  mbm_pkg::in_item_t req_i,
  input  logic              adv_i,
  output mbm_pkg::tx_beat_t beat_o
);
  import mbm_pkg::*;

  logic        busy_q, busy_d;
  logic [2:0]  idx_q, idx_d;
  logic [15:0] crc_q, crc_d;
  logic [7:0]  func_q, addr_q;
  logic [15:0] reg_q, cv_q;
  logic [7:0]  byte_sel;

  always_comb begin
    unique case (idx_q)
      3'd0:    byte_sel = addr_q;
      3'd1:    byte_sel = func_q;
      3'd2:    byte_sel = reg_q[15:8];
      3'd3:    byte_sel = reg_q[7:0];
      3'd4:    byte_sel = cv_q[15:8];
      3'd5:    byte_sel = cv_q[7:0];
      3'd6:    byte_sel = crc_q[7:0];
      default: byte_sel = crc_q[15:8];
    endcase
  end

  always_comb begin
    busy_d = busy_q;
    idx_d  = idx_q;
    crc_d  = crc_q;
    if (start_i) begin
      busy_d = 1'b1;
      idx_d  = 3'd0;
      crc_d  = CRC_INIT;
    end else if (busy_q && adv_i) begin
      idx_d = idx_q + 3'd1;
      // CRC covers the six header bytes only
      if (idx_q < 3'd6) begin
        crc_d = crc_feed(crc_q, byte_sel);
      end
      if (idx_q == 3'd7) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= 3'd0;
    end else begin
      busy_q <= busy_d;
      idx_q  <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    crc_q <= crc_d;
    if (start_i) begin
      func_q <= (req_i.req_type == REQ_READ) ? FUNC_READ : FUNC_WRITE;
      addr_q <= req_i.slave_addr;
      reg_q  <= req_i.reg_addr;
      cv_q   <= req_i.count_or_value;
    end
  end

  assign beat_o.valid = busy_q;
  assign beat_o.data  = byte_sel;
  assign beat_o.last  = (idx_q == 3'd7);

endmodule

/* rtl/modbus_rtu_master_frame_engine_top.sv */
// Channel  Dir  Handshake              Payload
// in       in   in_valid_i/in_stall_o    mbm_pkg::in_item_t  (request, rx byte, tick)
// out      out  out_valid_o/out_stall_i  mbm_pkg::out_item_t (tx byte, word, status)
// cfg      in   cfg_we_i                 cfg_wdata_i = timeout_ticks
//
// Received bytes and ticks are taken while idle and when the result register is free.
// A request is accepted, then eight frame beats follow, one per cycle while the output
// is not stalled, as set by the single result register; the CRC folds in each header
// byte as it leaves. A good read reply ends with its words from the word RAM, one beat
// per cycle while the output is not stalled. Reset is asynchronous and clears control
// state only; the word RAM is not cleared. A stalled result holds the input side.
module modbus_rtu_master_frame_engine_top #(
  parameter int MAX_WORDS = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  mbm_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output mbm_pkg::out_item_t out_data_o,
  input  logic               cfg_we_i,
  input  logic [15:0]        cfg_wdata_i
);
  import mbm_pkg::*;

  localparam int AW  = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
  localparam int WCW = $clog2(MAX_WORDS + 1);

  ctl_state_e  state_q, state_d;
  phase_e      phase_q, phase_d;
  logic [7:0]  rx_cnt_q, rx_cnt_d;
  logic [7:0]  exp_len_q, exp_len_d;
  logic [15:0] crc_q, crc_d;
  logic [15:0] tick_q, tick_d;
  logic [WCW-1:0] wcnt_q, wcnt_d;
  logic [7:0]  hold_q, hold_d;
  logic [AW-1:0] rd_ptr_q, rd_ptr_d;
  logic [15:0] timeout_q;

  logic        out_valid_q;
  out_item_t   out_data_q;
  out_item_t   out_next;
  logic        out_load;
  logic        out_free;
  logic        in_acc;

  logic        tx_start;
  tx_beat_t    tx_beat;
  logic        go_tx, go_words, tx_done, words_done;

  logic        ram_we;
  logic [15:0] ram_wdata;
  logic [15:0] ram_rdata;

  // scratch for the received-byte, tick and word paths
  logic [15:0] crc_new;
  logic [7:0]  exp_new;
  logic [8:0]  rx_inc;
  logic [15:0] tick_inc;
  logic        words_last;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != ST_IDLE) || !out_free;
  assign in_acc     = in_valid_i && !in_stall_o;

  assign crc_new  = crc_feed(crc_q, in_data_i.rx_byte);
  assign rx_inc   = {1'b0, rx_cnt_q} + 9'd1;
  assign tick_inc = tick_q + 16'd1;
  // exception flag on the function byte shortens the reply to five bytes
  assign exp_new  = (rx_cnt_q == FUNC_IDX && (in_data_i.rx_byte & EXC_MASK) != 8'h00)
                    ? EXC_LEN : exp_len_q;
  assign words_last = (WCW'(rd_ptr_q) + WCW'(1)) == wcnt_q;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (go_tx) begin
          state_d = ST_TX;
        end else if (go_words) begin
          state_d = ST_WORDS;
        end
      end
      ST_TX: begin
        if (tx_done) begin
          state_d = ST_IDLE;
        end
      end
      ST_WORDS: begin
        if (words_done) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath and results
  always_comb begin
    phase_d    = phase_q;
    rx_cnt_d   = rx_cnt_q;
    exp_len_d  = exp_len_q;
    crc_d      = crc_q;
    tick_d     = tick_q;
    wcnt_d     = wcnt_q;
    hold_d     = hold_q;
    rd_ptr_d   = rd_ptr_q;
    out_load   = 1'b0;
    out_next   = mk_status(STAT_OK);
    tx_start   = 1'b0;
    go_tx      = 1'b0;
    go_words   = 1'b0;
    tx_done    = 1'b0;
    words_done = 1'b0;
    ram_we     = 1'b0;
    ram_wdata  = {hold_q, in_data_i.rx_byte};

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          unique case (in_data_i.req_type)
            REQ_READ, REQ_WRITE: begin
              // a new request drops any pending one
              phase_d = PH_IDLE;
              if (in_data_i.req_type == REQ_READ &&
                  (in_data_i.count_or_value == 16'd0 ||
                   in_data_i.count_or_value > 16'(MAX_WORDS))) begin
                out_load = 1'b1;
                out_next = mk_status(STAT_FRAME);
              end else begin
                tx_start  = 1'b1;
                go_tx     = 1'b1;
                phase_d   = (in_data_i.req_type == REQ_READ) ? PH_READ : PH_WRITE;
                rx_cnt_d  = 8'd0;
                exp_len_d = (in_data_i.req_type == REQ_READ)
                            ? READ_HDR_LEN + {in_data_i.count_or_value[6:0], 1'b0}
                            : WRITE_LEN;
                crc_d     = CRC_INIT;
                tick_d    = 16'd0;
                wcnt_d    = '0;
                hold_d    = 8'h00;
              end
            end
            REQ_TICK: begin
              if (phase_q != PH_IDLE) begin
                tick_d = tick_inc;
                if (tick_inc >= timeout_q) begin
                  phase_d  = PH_IDLE;
                  out_load = 1'b1;
                  out_next = mk_status(STAT_TIMEOUT);
                end
              end
            end
            default: begin
              if (phase_q != PH_IDLE) begin
                crc_d     = crc_new;
                rx_cnt_d  = rx_inc[7:0];
                exp_len_d = exp_new;
                // data bytes: odd index holds the high byte, even index stores the word
                if (phase_q == PH_READ && rx_cnt_q >= DATA_IDX &&
                    ({1'b0, rx_cnt_q} + 9'd2) < {1'b0, exp_new}) begin
                  if (rx_cnt_q[0]) begin
                    hold_d = in_data_i.rx_byte;
                  end else if (wcnt_q < WCW'(MAX_WORDS)) begin
                    ram_we = 1'b1;
                    wcnt_d = wcnt_q + WCW'(1);
                  end
                end
                if (rx_inc >= {1'b0, exp_new}) begin
                  phase_d = PH_IDLE;
                  priority if (crc_new != 16'h0000) begin
                    out_load = 1'b1;
                    out_next = mk_status(STAT_CRC);
                  end else if (exp_new == EXC_LEN) begin
                    out_load = 1'b1;
                    out_next = mk_status(STAT_EXC);
                  end else if (phase_q == PH_WRITE || wcnt_q == '0) begin
                    out_load = 1'b1;
                    out_next = mk_status(STAT_OK);
                  end else begin
                    go_words = 1'b1;
                    rd_ptr_d = '0;
                  end
                end
              end
            end
          endcase
        end
      end
      ST_TX: begin
        if (tx_beat.valid && out_free) begin
          out_load         = 1'b1;
          out_next.kind    = KIND_TX;
          out_next.tx_byte = tx_beat.data;
          out_next.status  = STAT_OK;
          out_next.last    = tx_beat.last;
          tx_done          = tx_beat.last;
        end
      end
      ST_WORDS: begin
        if (out_free) begin
          out_load          = 1'b1;
          out_next.kind     = KIND_WORD;
          out_next.reg_word = ram_rdata;
          out_next.status   = STAT_OK;
          out_next.last     = words_last;
          if (words_last) begin
            words_done = 1'b1;
          end else begin
            rd_ptr_d = rd_ptr_q + AW'(1);
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      phase_q     <= PH_IDLE;
      rx_cnt_q    <= 8'd0;
      exp_len_q   <= 8'd0;
      crc_q       <= CRC_INIT;
      tick_q      <= 16'd0;
      wcnt_q      <= '0;
      hold_q      <= 8'h00;
      rd_ptr_q    <= '0;
      timeout_q   <= TIMEOUT_RST;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      phase_q   <= phase_d;
      rx_cnt_q  <= rx_cnt_d;
      exp_len_q <= exp_len_d;
      crc_q     <= crc_d;
      tick_q    <= tick_d;
      wcnt_q    <= wcnt_d;
      hold_q    <= hold_d;
      rd_ptr_q  <= rd_ptr_d;
      if (cfg_we_i) begin
        timeout_q <= cfg_wdata_i;
      end
      if (out_free) begin
        out_valid_q <= out_load;
      end
    end
  end

  // result register: load only into a free slot
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q <= out_next;
    end
  end

  mbm_frame_tx u_tx (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (tx_start),
    .req_i   (in_data_i),
    .adv_i   (out_free && (state_q == ST_TX)),
    .beat_o  (tx_beat)
  );

  // word store: written at the word count, read at the next pointer so the
  // registered read lines up with rd_ptr_q
  mbm_ram #(
    .WIDTH (16),
    .DEPTH (MAX_WORDS),
    .AW    (AW)
  ) u_words (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wcnt_q[AW-1:0]),
    .wdata_i (ram_wdata),
    .raddr_i (rd_ptr_d),
    .rdata_o (ram_rdata)
  );

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

/* rtl/mbm_checker.sv */
`include "modbus_rtu_master_frame_engine_top_defines.svh"

module mbm_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input mbm_pkg::in_item_t  in_data_i,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input mbm_pkg::out_item_t out_data_o
);
  import mbm_pkg::*;

  `MBM_ASSERT_NXT(a_out_hold, out_valid_o && out_stall_i,
                  out_valid_o && $stable(out_data_o), "stalled output beat changed")

  `MBM_ASSERT_IMP(a_tx_clean, out_valid_o && out_data_o.kind == KIND_TX,
                  out_data_o.status == STAT_OK && out_data_o.reg_word == 16'h0000,
                  "transmit beat carries word or status")

  `MBM_ASSERT_IMP(a_status_last, out_valid_o && out_data_o.kind == KIND_STATUS,
                  out_data_o.last && out_data_o.tx_byte == 8'h00 &&
                  out_data_o.reg_word == 16'h0000, "status beat malformed")

  `MBM_ASSERT_NXT(a_zero_count, in_valid_i && !in_stall_o &&
                  in_data_i.req_type == REQ_READ && in_data_i.count_or_value == 16'd0,
                  out_valid_o && out_data_o.kind == KIND_STATUS &&
                  out_data_o.status == STAT_FRAME, "zero read count not rejected")

endmodule

bind modbus_rtu_master_frame_engine_top mbm_checker u_mbm_checker (.*);
